[rtl/assert_macros.svh]
// Assertion macros used by the top level of the two-stack queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/tsq_pkg.sv]
// Shared types, sizes and codes of the two-stack queue.
package tsq_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int WORD_W      = 32;
    localparam int CFG_W       = 5;

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [CNT_W-1:0]         t_cnt;
    typedef logic [ADDR_W-1:0]        t_addr;

    localparam logic [CFG_W-1:0] CAP_RESET = 5'd16;

    // Commands
    localparam logic [1:0] CMD_PUSH = 2'd0;
    localparam logic [1:0] CMD_POP  = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_FULL    = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_BAD_IDX = 3'd3;
    localparam logic [2:0] ST_BLOCKED = 3'd4;

endpackage

[rtl/tsq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic                             i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/two_stack_queue.sv]
// Top level of the two-stack queue: sequencer, counts and result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | to block  | i_in_valid / o_in_stall    | i_cmd, i_push_value, i_read_index
//  out     | from block| o_out_valid / i_out_stall  | o_data_out, o_status,
//          |           |                            | o_element_count, o_full_flag
//  cfg     | to block  | i_cfg_valid / o_cfg_ready  | i_cfg_data (stack capacity)
//
//  A push, pop or read that needs no pour issues at most one memory access; the
//  registered read data then forms the result.
//  A pour (intake stack emptied into the output stack) moves one element per cycle
//  through the intake read port and output write port.
//  Synchronous active-low reset clears the counts and sets the capacity to 16;
//  the stores keep their contents, only entries below a count are ever read.
//  The result register frees the intake side: a new item is taken while a result
//  still waits on a stalled output; the block holds in its result step only when
//  a second result is ready before the first is taken.
module two_stack_queue (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // input item channel
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic [1:0]                 i_cmd,
    input  tsq_pkg::t_word             i_push_value,
    input  logic [4:0]                 i_read_index,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tsq_pkg::t_word             o_data_out,
    output logic [2:0]                 o_status,
    output logic [5:0]                 o_element_count,
    output logic                       o_full_flag,
    // configuration channel
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tsq_pkg::CFG_W-1:0]  i_cfg_data
);

    import tsq_pkg::*;

    `include "assert_macros.svh"

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POUR = 2'd1;
    localparam logic [1:0] S_RESP = 2'd2;

    // Source of the result data
    localparam logic [1:0] SEL_NONE = 2'd0;
    localparam logic [1:0] SEL_OUT  = 2'd1;
    localparam logic [1:0] SEL_IN   = 2'd2;

    // Control state
    logic [1:0]       r_state, n_state;
    t_cnt             r_ic, n_ic;          // intake stack count
    t_cnt             r_oc, n_oc;          // output stack count
    logic             r_wr_pend, n_wr_pend; // pour: intake read data due for write
    logic [CFG_W-1:0] r_cap_cfg, n_cap_cfg;
    logic             r_out_valid, n_out_valid;

    // Item payload held across the sequence
    logic [1:0]       r_cmd, n_cmd;
    t_word            r_value, n_value;
    logic [1:0]       r_sel, n_sel;
    logic [2:0]       r_status, n_status;

    // Result register
    t_word            r_data_out, n_data_out;
    logic [2:0]       r_status_out, n_status_out;
    logic [5:0]       r_count_out, n_count_out;
    logic             r_full_out, n_full_out;

    // Memory ports
    logic              in_we, in_re, out_we, out_re;
    t_addr             in_waddr, in_raddr, out_waddr, out_raddr;
    logic [WORD_W-1:0] in_wdata, out_wdata, in_rdata, out_rdata;

    // Derived values
    logic        w_in_xfer, w_cfg_xfer, w_out_free;
    logic [31:0] w_cap32, w_ic32, w_oc32, w_idx32, w_total32;
    logic [31:0] w_out_ridx32, w_in_ridx32, w_inflight;
    t_cnt        w_cap, w_oc_dec, w_ic_dec;
    logic        w_in_full, w_out_full;

    tsq_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_intake_ram (
        .i_clk   (i_clk),
        .i_we    (in_we),
        .i_waddr (in_waddr),
        .i_wdata (in_wdata),
        .i_re    (in_re),
        .i_raddr (in_raddr),
        .o_rdata (in_rdata)
    );

    tsq_ram #(.WIDTH(WORD_W), .DEPTH(STACK_DEPTH)) u_output_ram (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (out_waddr),
        .i_wdata (out_wdata),
        .i_re    (out_re),
        .i_raddr (out_raddr),
        .o_rdata (out_rdata)
    );

    // Handshakes: take items and configuration only between sequences
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_cfg_xfer  = i_cfg_valid && o_cfg_ready;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // Effective capacity: zero acts as one, clamp to the store depth
    always_comb begin
        w_cap32 = 32'(r_cap_cfg);
        if (w_cap32 < 32'd1) begin
            w_cap32 = 32'd1;
        end
        if (w_cap32 > 32'(STACK_DEPTH)) begin
            w_cap32 = 32'(STACK_DEPTH);
        end
    end
    assign w_cap = w_cap32[CNT_W-1:0];

    assign w_ic32       = 32'(r_ic);
    assign w_oc32       = 32'(r_oc);
    assign w_idx32      = 32'(i_read_index);
    assign w_total32    = w_ic32 + w_oc32;
    assign w_inflight   = w_total32 + 32'(r_wr_pend);
    assign w_out_ridx32 = w_oc32 - 32'd1 - w_idx32;   // queue order runs down the output stack
    assign w_in_ridx32  = w_idx32 - w_oc32;           // then up the intake stack
    assign w_oc_dec     = r_oc - t_cnt'(1);
    assign w_ic_dec     = r_ic - t_cnt'(1);
    assign w_in_full    = (r_ic >= w_cap);
    assign w_out_full   = (r_oc >= w_cap);

    always_comb begin
        n_state      = r_state;
        n_ic         = r_ic;
        n_oc         = r_oc;
        n_wr_pend    = r_wr_pend;
        n_cap_cfg    = r_cap_cfg;
        n_cmd        = r_cmd;
        n_value      = r_value;
        n_sel        = r_sel;
        n_status     = r_status;
        n_data_out   = r_data_out;
        n_status_out = r_status_out;
        n_count_out  = r_count_out;
        n_full_out   = r_full_out;
        n_out_valid  = r_out_valid;

        in_we     = 1'b0;
        in_waddr  = r_ic[ADDR_W-1:0];
        in_wdata  = r_value;
        in_re     = 1'b0;
        in_raddr  = w_in_ridx32[ADDR_W-1:0];
        out_we    = 1'b0;
        out_waddr = r_oc[ADDR_W-1:0];
        out_wdata = in_rdata;
        out_re    = 1'b0;
        out_raddr = w_oc_dec[ADDR_W-1:0];

        // Drop the held result once the consumer takes it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        if (w_cfg_xfer) begin
            n_cap_cfg = i_cfg_data;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_cmd    = i_cmd;
                    n_value  = i_push_value;
                    n_sel    = SEL_NONE;
                    n_status = ST_OK;
                    n_state  = S_RESP;
                    case (i_cmd)
                        CMD_PUSH: begin
                            if (w_in_full && w_out_full) begin
                                n_status = ST_FULL;
                            end else if (w_in_full && (r_oc != '0)) begin
                                n_status = ST_BLOCKED;
                            end else if (w_in_full) begin
                                n_state = S_POUR;
                            end else begin
                                in_we    = 1'b1;
                                in_waddr = r_ic[ADDR_W-1:0];
                                in_wdata = i_push_value;
                                n_ic     = r_ic + t_cnt'(1);
                            end
                        end
                        CMD_POP: begin
                            if ((r_ic == '0) && (r_oc == '0)) begin
                                n_status = ST_EMPTY;
                            end else if (r_oc == '0) begin
                                n_state = S_POUR;
                            end else begin
                                out_re    = 1'b1;
                                out_raddr = w_oc_dec[ADDR_W-1:0];
                                n_oc      = w_oc_dec;
                                n_sel     = SEL_OUT;
                            end
                        end
                        CMD_READ: begin
                            if (w_idx32 >= w_total32) begin
                                n_status = ST_BAD_IDX;
                            end else if (w_idx32 < w_oc32) begin
                                out_re    = 1'b1;
                                out_raddr = w_out_ridx32[ADDR_W-1:0];
                                n_sel     = SEL_OUT;
                            end else begin
                                in_re    = 1'b1;
                                in_raddr = w_in_ridx32[ADDR_W-1:0];
                                n_sel    = SEL_IN;
                            end
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end

            S_POUR: begin
                // Write back the element read last cycle onto the output stack
                if (r_wr_pend) begin
                    out_we    = 1'b1;
                    out_waddr = r_oc[ADDR_W-1:0];
                    out_wdata = in_rdata;
                    n_oc      = r_oc + t_cnt'(1);
                end
                // Read the next intake top
                if (r_ic != '0) begin
                    in_re     = 1'b1;
                    in_raddr  = w_ic_dec[ADDR_W-1:0];
                    n_ic      = w_ic_dec;
                    n_wr_pend = 1'b1;
                end else begin
                    n_wr_pend = 1'b0;
                end
                // Pour drained: finish the push or the pop
                if ((r_ic == '0) && !r_wr_pend) begin
                    n_state = S_RESP;
                    if (r_cmd == CMD_PUSH) begin
                        in_we    = 1'b1;
                        in_waddr = '0;
                        in_wdata = r_value;
                        n_ic     = t_cnt'(1);
                        n_sel    = SEL_NONE;
                    end else begin
                        out_re    = 1'b1;
                        out_raddr = w_oc_dec[ADDR_W-1:0];
                        n_oc      = w_oc_dec;
                        n_sel     = SEL_OUT;
                    end
                end
            end

            S_RESP: begin
                // Hold here until the result register is free; read data stays put
                if (w_out_free) begin
                    case (r_sel)
                        SEL_OUT: n_data_out = $signed(out_rdata);
                        SEL_IN:  n_data_out = $signed(in_rdata);
                        default: n_data_out = '0;
                    endcase
                    n_status_out = r_status;
                    n_count_out  = w_total32[5:0];
                    n_full_out   = w_in_full && w_out_full;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ic        <= '0;
            r_oc        <= '0;
            r_wr_pend   <= 1'b0;
            r_cap_cfg   <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ic        <= n_ic;
            r_oc        <= n_oc;
            r_wr_pend   <= n_wr_pend;
            r_cap_cfg   <= n_cap_cfg;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_value      <= n_value;
        r_sel        <= n_sel;
        r_status     <= n_status;
        r_data_out   <= n_data_out;
        r_status_out <= n_status_out;
        r_count_out  <= n_count_out;
        r_full_out   <= n_full_out;
    end

    assign o_out_valid     = r_out_valid;
    assign o_data_out      = r_data_out;
    assign o_status        = r_status_out;
    assign o_element_count = r_count_out;
    assign o_full_flag     = r_full_out;

    // Counts never pass the store depth
    `ASSERT_NOW(a_counts_in_range, i_clk, i_rst_n, 1'b1, (w_ic32 <= 32'(STACK_DEPTH)) && (w_oc32 <= 32'(STACK_DEPTH)), "stack count beyond store depth")
    // A pour starts only into an empty output stack
    `ASSERT_NOW(a_pour_into_empty, i_clk, i_rst_n, (r_state == S_IDLE) && (n_state == S_POUR), r_oc == '0, "pour started with output stack not empty")
    // Pouring moves elements and never loses or creates one
    `ASSERT_NEXT(a_pour_conserves, i_clk, i_rst_n, (r_state == S_POUR) && (n_state == S_POUR), $stable(w_inflight), "pour changed the element total")
    // A result is loaded only when the register is free
    `ASSERT_NOW(a_no_result_overrun, i_clk, i_rst_n, (r_state == S_RESP) && (n_state == S_IDLE), w_out_free, "result overwrote an untaken result")

endmodule
